// ===== rtl/svm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package svm_pkg;

	localparam int SAMPLE_WORDS = 16384;
	localparam int FRAC_BITS    = 10;
	localparam int ADDR_W       = $clog2(SAMPLE_WORDS);
	localparam int BANK_DEPTH   = SAMPLE_WORDS / 2;
	localparam int BANK_AW      = ADDR_W - 1;
	localparam int CNT_W        = 15;
	// one spare bit: the step can carry the phase past the largest count
	localparam int PHASE_W      = CNT_W + FRAC_BITS + 1;
	localparam int IDX_W        = PHASE_W - FRAC_BITS;
	localparam int CURSOR_W     = 17;

	localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
	localparam logic signed [15:0] S16_MIN = 16'sh8000;

	localparam logic [15:0] GAIN_UNITY = 16'h8000;
	localparam logic [15:0] STEP_UNITY = 16'h0400;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_MIX   = 2'd1,
		OP_START = 2'd2,
		OP_STOP  = 2'd3
	} svm_op_t;

	typedef enum logic [2:0] {
		CFG_SAMPLE_COUNT = 3'd0,
		CFG_STEREO       = 3'd1,
		CFG_LEFT_GAIN    = 3'd2,
		CFG_RIGHT_GAIN   = 3'd3,
		CFG_PHASE_STEP   = 3'd4,
		CFG_LOOPING      = 3'd5,
		CFG_PAUSED       = 3'd6,
		CFG_START_FRAME  = 3'd7
	} svm_cfg_idx_t;

	typedef struct packed {
		svm_op_t            op;
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		logic [ADDR_W-1:0]  sample_address;
		logic signed [15:0] sample_value;
	} svm_item_t;

	typedef struct packed {
		logic signed [15:0]  left_out;
		logic signed [15:0]  right_out;
		logic                voice_done;
		logic [CURSOR_W-1:0] play_cursor;
	} svm_result_t;

	typedef struct packed {
		logic [CNT_W-1:0] sample_count;
		logic             stereo;
		logic [15:0]      left_gain;
		logic [15:0]      right_gain;
		logic [15:0]      phase_step;
		logic             looping;
		logic             paused;
		logic [CNT_W-1:0] start_frame;
	} svm_cfg_t;

	// beat handed from the phase stage to the mix datapath
	typedef struct packed {
		logic                mix;
		logic                stereo;
		logic                odd;
		logic                zero;
		logic signed [15:0]  left_in;
		logic signed [15:0]  right_in;
		logic                voice_done;
		logic [CURSOR_W-1:0] play_cursor;
	} svm_issue_t;

	typedef struct packed {
		logic               we_even;
		logic               we_odd;
		logic [BANK_AW-1:0] waddr;
		logic signed [15:0] wdata;
		logic               re;
		logic [BANK_AW-1:0] raddr;
	} svm_ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/svm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/svm_voice.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svm_voice
	import svm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire svm_cfg_t     cfg,
	input  wire logic         accept,
	input  wire svm_item_t    item,
	output svm_issue_t        issue,
	output svm_ram_req_t      ram_req
);

	logic [PHASE_W-1:0] phase_q;
	logic               finished_q;
	logic [PHASE_W-1:0] phase_n;
	logic               finished_n;

	always_comb begin
		logic [IDX_W-1:0]   idx;
		logic [IDX_W-1:0]   idx_n;
		logic [IDX_W-1:0]   count_x;
		logic               active;
		logic               in_range;
		logic [PHASE_W-1:0] ph1;
		logic [PHASE_W-1:0] wrap;
		logic               past_end;
		logic [CNT_W-1:0]   first;
		logic [IDX_W+1:0]   cur4;
		logic [IDX_W+1:0]   cur2;

		idx      = phase_q[PHASE_W-1:FRAC_BITS];
		count_x  = IDX_W'(cfg.sample_count);
		active   = !cfg.paused && !finished_q;
		in_range = idx < count_x;
		ph1      = (active && in_range) ? phase_q + PHASE_W'(cfg.phase_step) : phase_q;
		past_end = ph1[PHASE_W-1:FRAC_BITS] >= count_x;
		wrap     = ph1 - (PHASE_W'(cfg.sample_count) << FRAC_BITS);
		first    = (cfg.start_frame < cfg.sample_count) ? cfg.start_frame : cfg.sample_count;

		phase_n    = phase_q;
		finished_n = finished_q;
		case (item.op)
			OP_MIX: begin
				if (active) begin
					phase_n = (past_end && cfg.looping) ? wrap : ph1;
					if (past_end && !cfg.looping) begin
						finished_n = 1'b1;
					end
				end
			end
			OP_START: begin
				phase_n    = PHASE_W'(first) << FRAC_BITS;
				finished_n = 1'b0;
			end
			OP_STOP: begin
				finished_n = 1'b1;
			end
			default: begin
			end
		endcase

		idx_n = phase_n[PHASE_W-1:FRAC_BITS];
		cur4  = {idx_n, 2'b00};
		cur2  = {1'b0, idx_n, 1'b0};

		issue.mix         = (item.op == OP_MIX) && active && in_range;
		issue.stereo      = cfg.stereo;
		issue.odd         = idx[0];
		// reads past the store give silence
		issue.zero        = cfg.stereo ? (idx >= IDX_W'(BANK_DEPTH))
		                               : (idx >= IDX_W'(SAMPLE_WORDS));
		issue.left_in     = item.left_in;
		issue.right_in    = item.right_in;
		issue.voice_done  = finished_n;
		issue.play_cursor = cfg.stereo ? cur4[CURSOR_W-1:0] : cur2[CURSOR_W-1:0];

		ram_req.re      = accept && issue.mix;
		ram_req.raddr   = cfg.stereo ? idx[BANK_AW-1:0] : idx[BANK_AW:1];
		ram_req.we_even = accept && (item.op == OP_LOAD) && !item.sample_address[0];
		ram_req.we_odd  = accept && (item.op == OP_LOAD) && item.sample_address[0];
		ram_req.waddr   = item.sample_address[ADDR_W-1:1];
		ram_req.wdata   = item.sample_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			finished_q <= 1'b1;
		end else if (accept) begin
			phase_q    <= phase_n;
			finished_q <= finished_n;
		end
	end

	a_stop_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == OP_STOP |=> finished_q)
		else $error("voice still active after stop");

	a_start_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == OP_START |=> !finished_q && phase_q[FRAC_BITS-1:0] == '0)
		else $error("start left voice finished or phase unaligned");

	a_load_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == OP_LOAD |-> ram_req.we_even != ram_req.we_odd)
		else $error("load must hit exactly one bank");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.re && (ram_req.we_even || ram_req.we_odd)))
		else $error("read and write issued for one beat");

endmodule

`default_nettype wire

// ===== rtl/svm_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svm_mix
	import svm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire svm_cfg_t           cfg,
	input  wire logic               accept,
	input  wire svm_issue_t         issue,
	output logic                    ready,
	input  wire logic signed [15:0] rdata_even,
	input  wire logic signed [15:0] rdata_odd,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output svm_result_t             result
);

	logic               v_s1;
	svm_issue_t         iss_s1;
	logic               v_s2;
	svm_issue_t         iss_s2;
	logic signed [17:0] scl_l_s2;
	logic signed [17:0] scl_r_s2;
	logic               en_out;
	logic               en_s2;
	logic               en_s1;

	// stages advance independently so bubbles collapse under a stall
	assign en_out = !result_valid || !result_stall;
	assign en_s2  = !v_s2 || en_out;
	assign en_s1  = !v_s1 || en_s2;
	assign ready  = en_s1;

	// s1: RAM data arrives, apply gains
	logic signed [15:0] word_l;
	logic signed [15:0] word_r;
	logic signed [32:0] prod_l;
	logic signed [32:0] prod_r;

	always_comb begin
		logic signed [16:0] gl;
		logic signed [16:0] gr;

		gl = signed'({1'b0, cfg.left_gain});
		gr = signed'({1'b0, cfg.right_gain});
		if (iss_s1.zero) begin
			word_l = '0;
			word_r = '0;
		end else if (iss_s1.stereo) begin
			word_l = rdata_even;
			word_r = rdata_odd;
		end else begin
			word_l = iss_s1.odd ? rdata_odd : rdata_even;
			word_r = word_l;
		end
		prod_l = word_l * gl;
		prod_r = word_r * gr;
	end

	// s2: saturating add onto the incoming frame
	logic signed [15:0] left_sat;
	logic signed [15:0] right_sat;

	always_comb begin
		logic signed [18:0] sum_l;
		logic signed [18:0] sum_r;

		sum_l = 19'(iss_s2.left_in) + 19'(scl_l_s2);
		sum_r = 19'(iss_s2.right_in) + 19'(scl_r_s2);
		if (sum_l[18:15] inside {4'b0000, 4'b1111}) begin
			left_sat = sum_l[15:0];
		end else begin
			left_sat = sum_l[18] ? S16_MIN : S16_MAX;
		end
		if (sum_r[18:15] inside {4'b0000, 4'b1111}) begin
			right_sat = sum_r[15:0];
		end else begin
			right_sat = sum_r[18] ? S16_MIN : S16_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= accept;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				result_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && accept) begin
			iss_s1 <= issue;
		end
		if (en_s2 && v_s1) begin
			iss_s2   <= iss_s1;
			// arithmetic shift is floor of product / 32768
			scl_l_s2 <= prod_l[32:15];
			scl_r_s2 <= iss_s1.stereo ? prod_r[32:15] : prod_l[32:15];
		end
		if (en_out && v_s2) begin
			result.left_out    <= iss_s2.mix ? left_sat : iss_s2.left_in;
			result.right_out   <= iss_s2.mix ? right_sat : iss_s2.right_in;
			result.voice_done  <= iss_s2.voice_done;
			result.play_cursor <= iss_s2.play_cursor;
		end
	end

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> v_s1 && v_s2 && result_valid)
		else $error("input held off with room in the pipe");

	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		en_out && v_s2 && !iss_s2.mix |=> result.left_out == $past(iss_s2.left_in)
		&& result.right_out == $past(iss_s2.right_in))
		else $error("unmixed beat not echoed");

endmodule

`default_nettype wire

// ===== rtl/sample_voice_mixer.sv =====
// One PCM playback voice mixed into a stereo stream.
// item channel (item_valid / item_stall / item): each beat is one op:
//   load a 16-bit word into the sample store, mix one stereo frame,
//   start the voice at start_frame, or stop it.
// result channel (result_valid / result_stall / result): exactly one beat
//   per item, in order: mixed or echoed frame, done flag, play cursor.
// cfg port: cfg_we / cfg_index / cfg_data, write only, while idle.
// Throughput: one item per clock while no stalled result fills the pipe.
//   An item's phase update and store access happen in its accept cycle, so
//   the next item need not wait for its result.
// Pipeline: three register stages (RAM read, gain multiply, saturating add).
// Store: two 8K-word banks (even / odd words) so both words of a stereo pair
//   read together; contents are undefined after reset until loaded.
// Reset: voice finished, phase zero, gains unity, step one frame per beat.
// A stalled result backs up the pipe; the input is stalled only once all
//   three stages hold a beat.
`timescale 1ns / 1ps
`default_nettype none

module sample_voice_mixer
	import svm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire svm_item_t   item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output svm_result_t      result
);

	svm_cfg_t     cfg_q;
	svm_issue_t   issue;
	svm_ram_req_t ram_req;
	logic         ready;
	logic         accept;
	logic [15:0]  rdata_even;
	logic [15:0]  rdata_odd;

	assign item_stall = !ready;
	assign accept     = item_valid && ready;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count <= '0;
			cfg_q.stereo       <= 1'b0;
			cfg_q.left_gain    <= GAIN_UNITY;
			cfg_q.right_gain   <= GAIN_UNITY;
			cfg_q.phase_step   <= STEP_UNITY;
			cfg_q.looping      <= 1'b0;
			cfg_q.paused       <= 1'b0;
			cfg_q.start_frame  <= '0;
		end else if (cfg_we) begin
			case (svm_cfg_idx_t'(cfg_index))
				CFG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data[CNT_W-1:0];
				CFG_STEREO:       cfg_q.stereo       <= cfg_data[0];
				CFG_LEFT_GAIN:    cfg_q.left_gain    <= cfg_data;
				CFG_RIGHT_GAIN:   cfg_q.right_gain   <= cfg_data;
				CFG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data;
				CFG_LOOPING:      cfg_q.looping      <= cfg_data[0];
				CFG_PAUSED:       cfg_q.paused       <= cfg_data[0];
				CFG_START_FRAME:  cfg_q.start_frame  <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// phase and voice state, store addressing
	svm_voice u_voice (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.item    (item),
		.issue   (issue),
		.ram_req (ram_req)
	);

	// even sample words
	svm_ram #(
		.WIDTH (16),
		.DEPTH (BANK_DEPTH)
	) u_ram_even (
		.clk   (clk),
		.we    (ram_req.we_even),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata_even)
	);

	// odd sample words
	svm_ram #(
		.WIDTH (16),
		.DEPTH (BANK_DEPTH)
	) u_ram_odd (
		.clk   (clk),
		.we    (ram_req.we_odd),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata_odd)
	);

	// gain, saturation and output register
	svm_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.issue        (issue),
		.ready        (ready),
		.rdata_even   (signed'(rdata_even)),
		.rdata_odd    (signed'(rdata_odd)),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
